[sv/svps_pkg.sv]
// ----------------------------------------------------------------------------
// svps_pkg
// Types and constants shared by the voice position stepper modules.
// ----------------------------------------------------------------------------
package svps_pkg;

  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_TRIGGER = 2'd1,
    OP_RATE    = 2'd2,
    OP_NONE    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    MODE_NONE     = 2'd0,
    MODE_FORWARD  = 2'd1,
    MODE_PINGPONG = 2'd2,
    MODE_ALT_FWD  = 2'd3
  } mode_e;

  localparam logic CFG_RATE_SCALE = 1'b0;
  localparam logic CFG_VOICES     = 1'b1;

  localparam logic [31:0] RATE_SCALE_RST = 32'd71582788;
  localparam logic [5:0]  VOICES_RST     = 6'd32;

  typedef enum logic [3:0] {
    ST_IDLE, ST_READ, ST_DECIDE, ST_MUL, ST_MUL2, ST_DIV, ST_FINISH, ST_OUT
  } state_e;

  // Work the sequencer has to do for the item in flight.
  typedef enum logic [2:0] {
    KIND_NONE = 3'd0,
    KIND_RATE = 3'd1,
    KIND_DIV  = 3'd2,
    KIND_TRIG = 3'd3,
    KIND_ADV  = 3'd4,
    KIND_STEP = 3'd5
  } kind_e;

  // Start and done of the shared remainder unit.
  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [30:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [30:0] rem;
  } div_rsp_t;

endpackage

[sv/svps_rem.sv]
// ----------------------------------------------------------------------------
// svps_rem
// Restoring remainder unit, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module svps_rem
  import svps_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic [31:0] num_q, num_d;
  logic [31:0] rem_q, rem_d;
  logic [30:0] den_q, den_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [32:0] trial;

  always_comb begin
    num_d  = num_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q, num_q[31]} - {2'b00, den_q};
    if (req_i.start) begin
      num_d  = req_i.dividend;
      den_d  = req_i.divisor;
      rem_d  = '0;
      cnt_d  = 6'd32;
      busy_d = 1'b1;
    end else if (busy_q) begin
      num_d = {num_q[30:0], 1'b0};
      if (!trial[32]) begin
        rem_d = trial[31:0];
      end else begin
        rem_d = {rem_q[30:0], num_q[31]};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.rem  = rem_q[30:0];

endmodule

[sv/sample_voice_position_stepper.sv]
// ----------------------------------------------------------------------------
// sample_voice_position_stepper
// Multi-voice playback position engine with forward and pingpong loops.
// ----------------------------------------------------------------------------
// One transaction is taken at a time. The result is registered in ST_OUT after
// the item passes ST_READ, ST_DECIDE and ST_FINISH for a trigger, an unknown op
// or a tick that needs no remainder; a set-rate item also passes ST_MUL and
// ST_MUL2, and a tick that wraps or reflects past a loop longer than one frame
// waits in ST_DIV for the shared 32-step remainder unit. The next input is
// taken only once the result transaction has been accepted and the sequencer
// is back in ST_IDLE. The per-voice state lives in small register arrays
// addressed by the voice number, and the rate multiplier is split into two
// 20x16 partial products, formed in ST_DECIDE and ST_MUL. No clearing pass is needed after reset.
module sample_voice_position_stepper
  import svps_pkg::*;
#(
  parameter int VOICES = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // tdata from bit 0: op(2) voice(5) sample_present(1) sample_length(31)
  // loop_begin(31) loop_size(31) loop_type(2) sample_16bit(1)
  // start_position(31) rate(20), zero padded to 160 bits
  input  logic [159:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tdata from bit 0: result_voice(5) sample_position(32) playing(1)
  output logic [39:0]  m_axis_tdata,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic         cfg_index_i,
  input  logic [31:0]  cfg_data_i
);

  localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;

  logic [31:0] rate_scale_q;
  logic [5:0]  voices_q;

  logic [30:0] pos_q   [VOICES];
  logic [15:0] frac_q  [VOICES];
  logic [31:0] step_q  [VOICES];
  logic [30:0] end_q   [VOICES];
  logic [30:0] lbeg_q  [VOICES];
  logic [30:0] llen_q  [VOICES];
  logic [1:0]  lmode_q [VOICES];
  logic [VOICES-1:0] back_q, act_q, wide_q, pend_q;
  logic [127:0] pf_q   [VOICES];

  state_e      st_q, st_d;
  logic [159:0] item_q;
  logic [VW-1:0] vi;
  logic        vok;

  // Working registers.
  logic [31:0] sum_q;
  logic [32:0] wpos_q;
  logic [47:0] prod_q;
  div_req_t    dreq;
  div_rsp_t    drsp;
  kind_e       kind_q;

  logic [39:0] out_q;
  logic        out_v_q;
  logic [31:0] out_pos;

  logic [32:0] npos;
  logic        need_div;
  logic        div_go;

  assign vi  = item_q[2+:VW];
  assign vok = {1'b0, item_q[6:2]} < 6'(VOICES);

  svps_rem u_rem (.clk_i, .rst_ni, .req_i(dreq), .rsp_o(drsp));

  assign s_axis_tready = (st_q == ST_IDLE) && !out_v_q;
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_scale_q <= RATE_SCALE_RST;
      voices_q     <= VOICES_RST;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CFG_RATE_SCALE) rate_scale_q <= cfg_data_i;
      else voices_q <= cfg_data_i[5:0];
    end
  end

  // Advance arithmetic on the registered sum.
  logic [30:0] cpos, cbeg, cend, clen;
  logic [15:0] whole;
  logic        cback;
  logic [1:0]  cmode;
  always_comb begin
    cpos  = pos_q[vi];
    cbeg  = lbeg_q[vi];
    cend  = end_q[vi];
    clen  = llen_q[vi];
    cback = back_q[vi];
    cmode = lmode_q[vi];
    whole = sum_q[31:16];
  end

  // Trigger decode.
  logic [127:0] pf;
  logic [30:0]  t_len, t_beg, t_sz;
  logic [1:0]   t_mode;
  logic [31:0]  t_end;
  always_comb begin
    pf     = pf_q[vi];
    t_len  = pf[31:1];
    t_beg  = pf[62:32];
    t_sz   = pf[93:63];
    if (pf[96]) begin
      t_len = t_len >> 1; t_beg = t_beg >> 1; t_sz = t_sz >> 1;
    end
    t_mode = (pf[95:94] == MODE_ALT_FWD) ? MODE_FORWARD : pf[95:94];
    if (t_sz == '0) t_mode = MODE_NONE;
    t_end  = (t_mode != MODE_NONE) ? ({1'b0, t_beg} + {1'b0, t_sz}) : {1'b0, t_len};
  end

  // A tick that crosses a loop boundary with a loop longer than one frame
  // needs the remainder unit.
  assign div_go = (kind_q == KIND_ADV) && (sum_q[31:16] != '0) && need_div;

  always_comb begin
    st_d = st_q;
    case (st_q)
      ST_IDLE:   if (s_axis_tvalid && s_axis_tready) st_d = ST_READ;
      ST_READ:   st_d = ST_DECIDE;
      ST_DECIDE: begin
        if (kind_q == KIND_RATE) st_d = ST_MUL;
        else if (div_go) st_d = ST_DIV;
        else st_d = ST_FINISH;
      end
      ST_MUL:    st_d = ST_MUL2;
      ST_MUL2:   st_d = ST_FINISH;
      ST_DIV:    if (drsp.done) st_d = ST_FINISH;
      ST_FINISH: st_d = ST_OUT;
      ST_OUT:    st_d = ST_IDLE;
      default:   st_d = ST_IDLE;
    endcase
  end

  always_comb begin
    dreq.start    = 1'b0;
    dreq.dividend = '0;
    dreq.divisor  = clen;
    npos     = '0;
    need_div = 1'b0;
    if (cback) begin
      npos = {2'b0, cpos} - {17'b0, whole} - 33'd1;
      if ($signed(npos) < $signed({2'b0, cbeg}) && clen > 31'd1) begin
        need_div = 1'b1;
        dreq.dividend = 32'({2'b0, cbeg} - npos - 33'd1);
      end
    end else begin
      npos = {2'b0, cpos} + {17'b0, whole};
      if (cmode != MODE_NONE && npos >= {2'b0, cend} && clen > 31'd1) begin
        need_div = 1'b1;
        dreq.dividend = 32'(npos - {2'b0, cend});
      end
    end
    dreq.start = (st_q == ST_DECIDE) && div_go;
  end

  always_comb begin
    out_pos = 32'hFFFF_FFFF;
    if (vok && !pend_q[vi] && act_q[vi] && pos_q[vi] < end_q[vi])
      out_pos = wide_q[vi] ? {pos_q[vi], 1'b0} : {1'b0, pos_q[vi]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= ST_IDLE;
      out_v_q <= 1'b0;
      back_q  <= '0;
      act_q   <= '0;
      wide_q  <= '0;
      pend_q  <= '0;
      kind_q  <= KIND_NONE;
      for (int i = 0; i < VOICES; i++) begin
        pos_q[i] <= '0; frac_q[i] <= '0; step_q[i] <= '0; lmode_q[i] <= MODE_NONE;
      end
    end else begin
      st_q <= st_d;
      if (out_v_q && m_axis_tready) out_v_q <= 1'b0;
      case (st_q)
        ST_IDLE: if (s_axis_tvalid && s_axis_tready) item_q <= s_axis_tdata;
        ST_READ: begin
          kind_q <= KIND_NONE;
          sum_q  <= {16'b0, frac_q[vi]} + step_q[vi];
          if (vok) begin
            if (item_q[1:0] == OP_TRIGGER) begin
              pf_q[vi]   <= item_q[134:7];
              pend_q[vi] <= 1'b1;
            end else if (item_q[1:0] == OP_RATE) begin
              kind_q <= KIND_RATE;
            end else if (item_q[1:0] == OP_TICK && {1'b0, item_q[6:2]} < voices_q) begin
              kind_q <= pend_q[vi] ? KIND_TRIG : act_q[vi] ? KIND_ADV : KIND_NONE;
            end
          end
        end
        ST_DECIDE: begin
          if (kind_q == KIND_TRIG) begin
            pend_q[vi] <= 1'b0;
            if (!pf[0] || pf[31:1] == '0) act_q[vi] <= 1'b0;
            else begin
              wide_q[vi]  <= pf[96];
              back_q[vi]  <= 1'b0;
              lbeg_q[vi]  <= t_beg;
              llen_q[vi]  <= t_sz;
              pos_q[vi]   <= pf[127:97];
              frac_q[vi]  <= '0;
              lmode_q[vi] <= t_mode;
              end_q[vi]   <= t_end[31] ? 31'd0 : t_end[30:0];
              act_q[vi]   <= !t_end[31] && (pf[127:97] < t_end[30:0]);
            end
            kind_q <= KIND_NONE;
          end else if (kind_q == KIND_ADV) begin
            frac_q[vi] <= sum_q[15:0];
            kind_q <= KIND_NONE;
            if (sum_q[31:16] != '0) begin
              wpos_q <= npos;
              kind_q <= need_div ? KIND_DIV : KIND_STEP;
            end
          end else if (kind_q == KIND_RATE) begin
            prod_q <= 48'(item_q[154:135]) * 48'(rate_scale_q[15:0]);
          end
        end
        ST_MUL: begin
          // Low partial product is registered; add the high one.
          prod_q <= (prod_q >> 16)
                  + 48'(item_q[154:135]) * 48'(rate_scale_q[31:16]);
        end
        ST_MUL2: begin
          step_q[vi] <= prod_q[31:0];
          kind_q <= KIND_NONE;
        end
        ST_FINISH: begin
          if (kind_q == KIND_DIV || kind_q == KIND_STEP) begin
            if (cback) begin
              if ($signed(wpos_q) < $signed({2'b0, cbeg})) begin
                back_q[vi] <= 1'b0;
                pos_q[vi] <= (kind_q == KIND_DIV) ? 31'(cbeg + drsp.rem) : cbeg;
              end else begin
                pos_q[vi] <= $signed(wpos_q) < 0 ? 31'd0 : wpos_q[30:0];
              end
            end else if (wpos_q >= {2'b0, cend}) begin
              if (cmode == MODE_NONE) act_q[vi] <= 1'b0;
              else if (cmode == MODE_PINGPONG) begin
                back_q[vi] <= 1'b1;
                pos_q[vi] <= 31'(cend - 31'd1 - ((kind_q == KIND_DIV) ? drsp.rem : 31'd0));
              end else begin
                pos_q[vi] <= 31'(cbeg + ((kind_q == KIND_DIV) ? drsp.rem : 31'd0));
              end
            end else begin
              pos_q[vi] <= wpos_q[30:0];
            end
          end
        end
        ST_OUT: begin
          out_v_q <= 1'b1;
          out_q   <= {2'b00, vok ? act_q[vi] : 1'b0, out_pos, item_q[6:2]};
        end
        default: ;
      endcase
    end
  end

`ifndef SYNTH
  a_busy_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q != ST_IDLE) |-> !s_axis_tready) else $error("accept while busy");
  a_div_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    drsp.busy |-> (st_q == ST_DIV)) else $error("divider outside divide");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
    else $error("result changed while stalled");
`endif

endmodule
